>>> rtl/sls_pkg.sv
// ---------------------------------------------------------------------------
// sls_pkg: shared types and constants of the status LED sequencer
// Mode and command codes, LED bit positions, item and configuration types.
// ---------------------------------------------------------------------------
package sls_pkg;

  // widths fixed by the stream fields
  localparam int TIMER_W     = 32;
  localparam int PAUSE_CNT_W = 8;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;

  // machine states / modes
  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_INIT  = 2'd1;
  localparam logic [1:0] M_READY = 2'd2;
  localparam logic [1:0] M_HOLD  = 2'd3;

  // commands
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_INIT   = 3'd1;
  localparam logic [2:0] CMD_READY  = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;

  // logging status
  localparam logic [1:0] LOG_RUNNING   = 2'd1;
  localparam logic [1:0] LOG_FINISHING = 2'd2;

  // LED bit positions in led_levels
  localparam int LED_RED = 0;
  localparam int LED_AMB = 1;
  localparam int LED_GRN = 2;
  localparam int LED_BLU = 3;

  // configuration register indexes
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [1:0] REG_RAM_BUF      = 2'd1;
  localparam logic [1:0] REG_TARGET_BUF   = 2'd2;
  localparam logic [1:0] REG_AVG_LIMIT    = 2'd3;

  // one input beat, unpacked
  typedef struct packed {
    logic [2:0]         command;
    logic [TIMER_W-1:0] timer_now;
    logic [1:0]         logging_state;
    logic               target_is_ram;
    logic               target_idle;
    logic               network_ready;
    logic               button_pressed;
    logic [15:0]        adc_backlog_max;
    logic [15:0]        target_backlog_max;
    logic [15:0]        delay_average;
    logic [23:0]        delay_total;
  } item_t;

  // thresholds used by the LED refresh
  typedef struct packed {
    logic [15:0] ram_buffer_size;
    logic [15:0] target_buffer_size;
    logic [15:0] average_limit;
  } thresh_t;

endpackage

>>> rtl/sls_led_refresh.sv
// ---------------------------------------------------------------------------
// sls_led_refresh: LED refresh rules for ready mode
// Computes the next four LED levels from logging status and backlog stats.
// ---------------------------------------------------------------------------
module sls_led_refresh import sls_pkg::*; (
  input  item_t      item,
  input  thresh_t    thresh,
  input  logic [3:0] led_levels,
  output logic [3:0] led_levels_next
);

  logic [17:0] t_x3;
  logic [15:0] t_3q;
  logic [15:0] t_8th;
  logic        red_steady;
  logic        red_blink;
  logic        logging;

  assign t_x3    = {2'b00, thresh.target_buffer_size} + {1'b0, thresh.target_buffer_size, 1'b0};
  assign t_3q    = t_x3[17:2];
  assign t_8th   = {3'b000, thresh.target_buffer_size[15:3]};
  assign logging = (item.logging_state == LOG_RUNNING) ||
                   (item.logging_state == LOG_FINISHING);

  assign red_steady = (item.adc_backlog_max >= thresh.ram_buffer_size) ||
                      (item.target_backlog_max >= thresh.target_buffer_size);
  assign red_blink  = (item.delay_total > {8'h00, t_3q}) ||
                      ((item.delay_average > thresh.average_limit) &&
                       (item.delay_total > {8'h00, t_8th}));

  always_comb begin
    led_levels_next = led_levels;
    // green: steady while running, else toggles
    if (item.logging_state == LOG_RUNNING) begin
      led_levels_next[LED_GRN] = 1'b1;
    end else begin
      led_levels_next[LED_GRN] = ~led_levels[LED_GRN];
    end
    // blue follows network readiness
    led_levels_next[LED_BLU] = item.network_ready;
    // orange: target logging activity
    if (logging && !item.target_is_ram) begin
      led_levels_next[LED_AMB] = item.target_idle ? ~led_levels[LED_AMB] : 1'b1;
    end else begin
      led_levels_next[LED_AMB] = 1'b0;
    end
    // red: overrun steady, near-overrun blinks
    priority if (red_steady) begin
      led_levels_next[LED_RED] = 1'b1;
    end else if (red_blink) begin
      led_levels_next[LED_RED] = ~led_levels[LED_RED];
    end else begin
      led_levels_next[LED_RED] = 1'b0;
    end
  end

endmodule

>>> rtl/status_led_sequencer_unit.sv
// ---------------------------------------------------------------------------
// status_led_sequencer_unit: four-LED status sequencer
// Mode sequencing, pause/resume holding and periodic LED refresh.
// ---------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis side carries one command with the current timer
//   value and logging statistics. Each accepted beat yields exactly one beat
//   on the m_axis side with the LED levels, stop request, machine state and
//   resume fault flag.
//   Path: a beat is taken into an input register, evaluated against the
//   sequencer state by one combinational pass, and lands in the output
//   register.
//   Throughput: one beat per cycle while m_axis_tready does not stall, set
//   by the state update between input and output registers.
//   The input side keeps accepting while a result waits, as long as the
//   input register is empty or moves on; a stalled m_axis_tready holds one
//   result and one pending beat, then drops s_axis_tready.
//   Reset (rst, synchronous) restores the register defaults, state idle,
//   pending mode init, LEDs off, pause count and blink time zero.
//   Configuration writes (cfg_we) take effect at once; write them only idle.
// ---------------------------------------------------------------------------
module status_led_sequencer_unit import sls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // s_axis_tdata, from bit 0: command[3], timer_now[32], logging_state[2],
  // target_is_ram, target_idle, network_ready, button_pressed,
  // adc_backlog_max[16], target_backlog_max[16], delay_average[16],
  // delay_total[24], zero fill[7]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // m_axis_tdata, from bit 0: red, orange, green and blue LED levels,
  // stop_request, machine_state[2], fault
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  // configuration registers
  logic [TIMER_W-1:0] blink_period;
  thresh_t            thresh;

  // sequencer state
  logic [1:0]             machine_state;
  logic [1:0]             current_mode;
  logic [2:0]             pending_mode;
  logic [PAUSE_CNT_W-1:0] pause_count;
  logic [TIMER_W-1:0]     last_blink;
  logic [3:0]             led_levels;

  logic [1:0]             machine_state_next;
  logic [1:0]             current_mode_next;
  logic [2:0]             pending_mode_next;
  logic [PAUSE_CNT_W-1:0] pause_count_next;
  logic [TIMER_W-1:0]     last_blink_next;
  logic [3:0]             led_levels_next;
  logic                   stop_next;
  logic                   fault_next;

  // input register
  item_t item;
  logic  in_full;
  logic  advance;

  logic [2:0]         cmd;
  logic [TIMER_W-1:0] elapsed;
  logic [3:0]         refreshed;

  assign advance       = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period              <= TIMER_W'(25000000);
      thresh.ram_buffer_size    <= 16'd4096;
      thresh.target_buffer_size <= 16'd4096;
      thresh.average_limit      <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_PERIOD: blink_period              <= cfg_data;
        REG_RAM_BUF:      thresh.ram_buffer_size    <= cfg_data[15:0];
        REG_TARGET_BUF:   thresh.target_buffer_size <= cfg_data[15:0];
        REG_AVG_LIMIT:    thresh.average_limit      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.command            <= s_axis_tdata[2:0];
      item.timer_now          <= s_axis_tdata[34:3];
      item.logging_state      <= s_axis_tdata[36:35];
      item.target_is_ram      <= s_axis_tdata[37];
      item.target_idle        <= s_axis_tdata[38];
      item.network_ready      <= s_axis_tdata[39];
      item.button_pressed     <= s_axis_tdata[40];
      item.adc_backlog_max    <= s_axis_tdata[56:41];
      item.target_backlog_max <= s_axis_tdata[72:57];
      item.delay_average      <= s_axis_tdata[88:73];
      item.delay_total        <= s_axis_tdata[112:89];
    end
  end

  // LED rules for the periodic refresh
  sls_led_refresh u_refresh (
    .item            (item),
    .thresh          (thresh),
    .led_levels      (led_levels),
    .led_levels_next (refreshed)
  );

  assign elapsed = item.timer_now - last_blink;

  // sequencer step for the registered beat
  always_comb begin
    machine_state_next = machine_state;
    current_mode_next  = current_mode;
    pending_mode_next  = pending_mode;
    pause_count_next   = pause_count;
    last_blink_next    = last_blink;
    led_levels_next    = led_levels;
    stop_next          = 1'b0;
    fault_next         = 1'b0;

    cmd = (item.command > CMD_RESUME) ? CMD_NONE : item.command;

    // pause blanks the LEDs and holds
    if (cmd == CMD_PAUSE) begin
      led_levels_next    = 4'b0000;
      machine_state_next = M_HOLD;
      cmd                = CMD_NONE;
      if (pause_count != {PAUSE_CNT_W{1'b1}}) begin
        pause_count_next = pause_count + PAUSE_CNT_W'(1);
      end
    end
    // resume outside hold is a fault
    if (cmd == CMD_RESUME && machine_state_next != M_HOLD) begin
      fault_next = 1'b1;
      cmd        = CMD_NONE;
    end
    if (cmd != CMD_NONE) begin
      pending_mode_next = cmd;
    end

    // idle picks up a new mode
    if (machine_state_next == M_IDLE && {1'b0, current_mode} != pending_mode_next) begin
      machine_state_next = pending_mode_next[1:0];
      current_mode_next  = pending_mode_next[1:0];
    end

    unique case (machine_state_next)
      M_IDLE: begin
        if (current_mode_next == M_READY) begin
          if (elapsed > blink_period) begin
            last_blink_next = item.timer_now;
            led_levels_next = refreshed;
          end
          stop_next = (item.logging_state == LOG_RUNNING) && item.button_pressed;
        end
      end
      M_INIT: begin
        led_levels_next          = 4'b0000;
        led_levels_next[LED_AMB] = 1'b1;
        machine_state_next       = M_IDLE;
      end
      M_READY: begin
        led_levels_next          = 4'b0000;
        led_levels_next[LED_GRN] = 1'b1;
        last_blink_next          = item.timer_now;
        machine_state_next       = M_IDLE;
      end
      M_HOLD: begin
        if (pending_mode_next == CMD_RESUME) begin
          // count pauses down, restore the mode at zero
          if (pause_count_next != '0) begin
            pause_count_next = pause_count_next - PAUSE_CNT_W'(1);
          end
          if (pause_count_next == '0) begin
            pending_mode_next  = {1'b0, current_mode_next};
            machine_state_next = current_mode_next;
          end
        end else if (cmd != CMD_NONE && {1'b0, current_mode_next} != cmd) begin
          current_mode_next = cmd[1:0];
        end
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      machine_state <= M_IDLE;
      current_mode  <= M_IDLE;
      pending_mode  <= CMD_INIT;
      pause_count   <= '0;
      last_blink    <= '0;
      led_levels    <= 4'b0000;
    end else if (advance) begin
      machine_state <= machine_state_next;
      current_mode  <= current_mode_next;
      pending_mode  <= pending_mode_next;
      pause_count   <= pause_count_next;
      last_blink    <= last_blink_next;
      led_levels    <= led_levels_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {fault_next, machine_state_next, stop_next, led_levels_next};
    end
  end

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for status_led_sequencer_unit
// Streams command beats with random idle gaps on both sides, predicts each
// status beat from a software copy of the sequencer and compares every field.
// ---------------------------------------------------------------------------
module testbench import sls_pkg::*; ();

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 72;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_OFF_LEN = 300;
  localparam int MAX_REPORTS  = 10;

  // out-of-range command codes, treated by the block as no command
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  // one status beat, msb first (m_axis_tdata layout)
  typedef struct packed {
    logic       fault;
    logic [1:0] machine_state;
    logic       stop_request;
    logic [3:0] leds;
  } status_t;

  // predicts the status beats of the sequencer and checks them in order
  class status_predictor;
    logic [31:0]            blink_period;
    thresh_t                thr;
    logic [1:0]             state_q;
    logic [1:0]             mode_q;
    logic [2:0]             pend_q;
    logic [PAUSE_CNT_W-1:0] pause_q;
    logic [31:0]            last_blink;
    logic [3:0]             leds;
    status_t                expected_status[$];
    int                     errors;

    function new();
      blink_period = 32'd25000000;
      thr          = {16'd4096, 16'd4096, 16'd100};
      state_q      = M_IDLE;
      mode_q       = M_IDLE;
      pend_q       = CMD_INIT;
      pause_q      = '0;
      last_blink   = '0;
      leds         = '0;
      errors       = 0;
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    // advance the sequencer copy by one accepted command beat
    function void take_command(item_t it);
      logic [2:0]  cmd;
      logic        fault;
      logic        stop;
      logic [31:0] since;
      logic [31:0] tsize;
      logic [31:0] total;
      logic [3:0]  lv;
      status_t     st;
      cmd   = it.command;
      fault = 1'b0;
      stop  = 1'b0;
      if (cmd > CMD_RESUME) cmd = CMD_NONE;

      // pause blanks at once and bumps the saturating pause count
      if (cmd == CMD_PAUSE) begin
        leds    = '0;
        state_q = M_HOLD;
        cmd     = CMD_NONE;
        if (pause_q != '1) pause_q++;
      end
      if (cmd == CMD_RESUME && state_q != M_HOLD) begin
        fault = 1'b1;
        cmd   = CMD_NONE;
      end
      if (cmd != CMD_NONE) pend_q = cmd;

      if (state_q == M_IDLE && {1'b0, mode_q} != pend_q) begin
        state_q = pend_q[1:0];
        mode_q  = pend_q[1:0];
      end

      case (state_q)
        M_IDLE: begin
          if (mode_q == M_READY) begin
            since = it.timer_now - last_blink;
            // periodic refresh of the four LEDs
            if (since > blink_period) begin
              last_blink = it.timer_now;
              lv    = leds;
              tsize = 32'(thr.target_buffer_size);
              total = 32'(it.delay_total);
              if (it.logging_state == LOG_RUNNING) lv[LED_GRN] = 1'b1;
              else lv[LED_GRN] = ~lv[LED_GRN];
              lv[LED_BLU] = it.network_ready;
              if ((it.logging_state == LOG_RUNNING || it.logging_state == LOG_FINISHING)
                  && !it.target_is_ram) begin
                if (it.target_idle) lv[LED_AMB] = ~lv[LED_AMB];
                else lv[LED_AMB] = 1'b1;
              end else begin
                lv[LED_AMB] = 1'b0;
              end
              if (it.adc_backlog_max >= thr.ram_buffer_size ||
                  it.target_backlog_max >= thr.target_buffer_size)
                lv[LED_RED] = 1'b1;
              else if (total > (32'd3 * tsize) / 32'd4 ||
                       (it.delay_average > thr.average_limit && total > tsize / 32'd8))
                lv[LED_RED] = ~lv[LED_RED];
              else
                lv[LED_RED] = 1'b0;
              leds = lv;
            end
            stop = (it.logging_state == LOG_RUNNING) && it.button_pressed;
          end
        end
        M_INIT: begin
          leds = '0;
          leds[LED_AMB] = 1'b1;
          state_q = M_IDLE;
        end
        M_READY: begin
          leds = '0;
          leds[LED_GRN] = 1'b1;
          last_blink = it.timer_now;
          state_q = M_IDLE;
        end
        default: begin
          // hold: drain pending resume, or retarget the remembered mode
          if (pend_q == CMD_RESUME) begin
            if (pause_q != '0) pause_q--;
            if (pause_q == '0) begin
              pend_q  = {1'b0, mode_q};
              state_q = mode_q;
            end
          end else if (cmd != CMD_NONE && {1'b0, mode_q} != cmd) begin
            mode_q = cmd[1:0];
          end
        end
      endcase

      st.fault         = fault;
      st.machine_state = state_q;
      st.stop_request  = stop;
      st.leds          = leds;
      expected_status.push_back(st);
    endfunction

    // compare one status beat against the oldest prediction
    function void check_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("status beat %h arrived with nothing predicted", got);
        return;
      end
      want = expected_status.pop_front();
      if (got.leds !== want.leds || got.stop_request !== want.stop_request ||
          got.machine_state !== want.machine_state || got.fault !== want.fault) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("status mismatch: exp leds %b stop %b state %0d fault %b",
                   want.leds, want.stop_request, want.machine_state, want.fault);
          $display("                 got leds %b stop %b state %0d fault %b",
                   got.leds, got.stop_request, got.machine_state, got.fault);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = REG_BLINK_PERIOD;
  logic [31:0]            cfg_data = '0;

  status_predictor sb = new();
  bit          burst_mode = 1'b0;
  bit          hold_off_req = 1'b0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [31:0] timer_ticks = '0;

  status_led_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none in burst phases
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // backlog values clustered around a threshold
  function automatic logic [15:0] near16(logic [15:0] th);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return th + 16'($urandom_range(0, 2)) - 16'd1;
      2:       return 16'($urandom_range(0, th));
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  // command beat with random content; timer half the time near the refresh edge
  function automatic item_t random_item(logic [2:0] cmd);
    item_t       it;
    logic [31:0] tsize;
    tsize = 32'(sb.thr.target_buffer_size);
    case ($urandom_range(0, 9))
      0:             timer_ticks = $urandom;
      1, 2, 3, 4, 5: timer_ticks = sb.last_blink + sb.blink_period +
                                   32'($urandom_range(0, 2)) - 32'd1;
      default:       timer_ticks = timer_ticks + 32'($urandom_range(0, 100));
    endcase
    it.command            = cmd;
    it.timer_now          = timer_ticks;
    it.logging_state      = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.target_is_ram      = 1'($urandom_range(0, 1));
    it.target_idle        = 1'($urandom_range(0, 1));
    it.network_ready      = 1'($urandom_range(0, 1));
    it.button_pressed     = 1'($urandom_range(0, 1));
    it.adc_backlog_max    = near16(sb.thr.ram_buffer_size);
    it.target_backlog_max = near16(sb.thr.target_buffer_size);
    it.delay_average      = near16(sb.thr.average_limit);
    case ($urandom_range(0, 3))
      0:       it.delay_total = 24'($urandom);
      1:       it.delay_total = 24'((32'd3 * tsize) / 32'd4 + 32'($urandom_range(0, 1)));
      2:       it.delay_total = 24'(tsize / 32'd8 + 32'($urandom_range(0, 1)));
      default: it.delay_total = 24'($urandom_range(0, 300));
    endcase
    return it;
  endfunction

  // offer one beat after an optional gap, note it once accepted
  task automatic send_item(item_t it);
    int                    gap;
    logic [IN_TDATA_W-1:0] d;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d = '0;
    d[2:0]    = it.command;
    d[34:3]   = it.timer_now;
    d[36:35]  = it.logging_state;
    d[37]     = it.target_is_ram;
    d[38]     = it.target_idle;
    d[39]     = it.network_ready;
    d[40]     = it.button_pressed;
    d[56:41]  = it.adc_backlog_max;
    d[72:57]  = it.target_backlog_max;
    d[88:73]  = it.delay_average;
    d[112:89] = it.delay_total;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_command(it);
    items_sent++;
  endtask

  task automatic send_cmd(logic [2:0] cmd);
    send_item(random_item(cmd));
  endtask

  // stop offering and wait for every predicted beat plus pipeline slack
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] period, logic [15:0] ram_sz,
                              logic [15:0] trg_sz, logic [15:0] avg_lim);
    write_reg(REG_BLINK_PERIOD, period);
    write_reg(REG_RAM_BUF, 32'(ram_sz));
    write_reg(REG_TARGET_BUF, 32'(trg_sz));
    write_reg(REG_AVG_LIMIT, 32'(avg_lim));
    cfg_we <= 1'b0;
    sb.blink_period = period;
    sb.thr = {ram_sz, trg_sz, avg_lim};
  endtask

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_status(status_t'(m_axis_tdata));
      if (hold_off_req) begin
        stall_left = HOLD_OFF_LEN;
        hold_off_req = 1'b0;
      end
      if (stall_left == 0 && !burst_mode && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence: directed beats, then random phases under several settings
  initial begin
    item_t it;
    int    k;
    int    phase_end;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first beat shows init without a command; stray resume and unknown codes
    send_cmd(CMD_NONE);
    send_cmd(CMD_NONE);
    send_cmd(CMD_RESUME);
    send_cmd(CMD_UNKNOWN_LO);
    send_cmd(CMD_UNKNOWN_HI);
    // ready, then the refresh boundary: equal to the period, then one past twice the period
    it = random_item(CMD_READY);
    it.timer_now = 32'd100;
    send_item(it);
    it = random_item(CMD_NONE);
    it.timer_now = 32'd100 + sb.blink_period;
    send_item(it);
    it = '1;
    it.command = CMD_NONE;
    it.logging_state = LOG_RUNNING;
    it.timer_now = 32'd101 + 32'd2 * sb.blink_period;
    send_item(it);
    // all ones: unknown command, logging code 3, timer at its top
    it = '1;
    send_item(it);
    // all zeros with a refresh across the timer wrap
    it = '0;
    it.timer_now = sb.blink_period + 32'd10;
    send_item(it);
    send_cmd(CMD_NONE);
    // pauses, mode change in hold, resume and drain
    send_cmd(CMD_PAUSE);
    send_cmd(CMD_PAUSE);
    send_cmd(CMD_NONE);
    send_cmd(CMD_INIT);
    send_cmd(CMD_RESUME);
    send_cmd(CMD_NONE);
    send_cmd(CMD_NONE);
    send_cmd(CMD_NONE);
    send_cmd(CMD_READY);
    send_cmd(CMD_NONE);
    send_cmd(CMD_NONE);

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      drain();
      case (phase)
        1:       program_regs(32'd0, 16'd1, 16'd1, 16'd0);
        2:       program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3:       program_regs(32'd40, 16'd1500, 16'd1200, 16'd60);
        4:       program_regs($urandom_range(0, 500), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 65535)), 16'($urandom));
        5:       program_regs(32'd1, 16'hFFFF, 16'd1, 16'hFFFF);
        default: program_regs(32'd25000000, 16'd4096, 16'd4096, 16'd100);
      endcase
      burst_mode = (phase == 5) || ($urandom_range(0, 4) == 0);
      if (phase == 2) hold_off_req = 1'b1;
      // saturate the pause count, then let one resume count it all down
      if (phase == 3) begin
        repeat (260) send_cmd(CMD_PAUSE);
        send_cmd(CMD_RESUME);
        repeat (258) send_cmd(CMD_NONE);
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // steady ready operation, rare stray command
            if ($urandom_range(0, 1) != 0) send_cmd(CMD_READY);
            repeat ($urandom_range(5, 30))
              send_cmd(($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE);
          end
          4, 5, 6: begin
            // pause burst, optional mode change, resume and drain
            k = $urandom_range(1, 4);
            repeat (k) send_cmd(CMD_PAUSE);
            repeat ($urandom_range(0, 3))
              send_cmd(($urandom_range(0, 3) == 0) ?
                       (($urandom_range(0, 1) != 0) ? CMD_INIT : CMD_READY) : CMD_NONE);
            send_cmd(CMD_RESUME);
            repeat (k + 2) send_cmd(CMD_NONE);
          end
          7: begin
            send_cmd(CMD_INIT);
            repeat ($urandom_range(1, 5)) send_cmd(CMD_NONE);
            send_cmd(CMD_READY);
          end
          default: begin
            // noise: any command code
            repeat ($urandom_range(3, 8)) send_cmd(3'($urandom_range(0, 7)));
          end
        endcase
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
